// ----- rtl/core/block_buffer_cache_pool_assert.svh -----
// assertion macros for the buffer cache pool
`ifndef BLOCK_BUFFER_CACHE_POOL_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_POOL_ASSERT_SVH
`ifndef SYNTHESIS
`define BBCP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("buffer cache pool check failed");
`define BBCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buffer cache pool check failed");
`else
`define BBCP_ASSERT(label, clk, rst, prop)
`define BBCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/bbcp_pkg.sv -----
// shared types and constants of the buffer cache pool
`default_nettype none
package bbcp_pkg;
  localparam int NUM_BUFFERS = 16;
  localparam int SLOT_W = $clog2(NUM_BUFFERS);
  localparam int COUNT_W = SLOT_W + 1;
  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_NOBUF    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_BADREL   = 3'd4
  } status_t;

  typedef enum logic {
    MODE_GET     = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } ring_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] head_slot;
  } ring_stat_t;

  typedef struct packed {
    logic              alloc;
    logic              release_en;
    logic [SLOT_W-1:0] slot;
  } tag_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              rel_in_use;
  } tag_stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/block_buffer_cache_pool.sv -----
// top level of the buffer cache pool
// A pool of sixteen buffer slots tagged by device and block number. A get item
// returns the matching in-use slot (hit), or takes the oldest slot from a fifo
// free ring and tags it (miss, data to be fetched), or reports no free buffer.
// A release item frees an in-use slot to the tail of the ring, and flags a
// release of a slot not in use. Each item passes an input register, a stage of
// parallel tag compare and ring update, and a result register; one item is taken
// every cycle while the result side keeps up. After reset the ring holds the
// slots in descending order, with no clearing pass.
`default_nettype none
module block_buffer_cache_pool
  import bbcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [DEV_W-1:0]  device_id,
  input  wire logic [BLK_W-1:0]  block_number,
  input  wire logic [SLOT_W-1:0] slot_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SLOT_W-1:0]      result_slot,
  output logic [STATUS_W-1:0]    status
);
  logic              s1_valid;
  logic              s1_mode;
  logic [DEV_W-1:0]  s1_dev;
  logic [BLK_W-1:0]  s1_blk;
  logic [SLOT_W-1:0] s1_idx;
  logic              adv;
  logic              fire;
  ring_ctrl_t        ring_ctrl;
  ring_stat_t        ring_stat;
  tag_ctrl_t         tag_ctrl;
  tag_stat_t         tag_stat;
  logic [SLOT_W-1:0] slot_next;
  status_t           status_next;

  assign adv = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;
  assign fire = s1_valid && adv;

  always_comb begin
    ring_ctrl = '0;
    tag_ctrl = '0;
    slot_next = s1_idx;
    status_next = ST_BADREL;
    if (s1_mode == MODE_GET) begin
      if (tag_stat.hit) begin
        slot_next = tag_stat.hit_slot;
        status_next = ST_HIT;
      end else if (ring_stat.empty) begin
        slot_next = '0;
        status_next = ST_NOBUF;
      end else begin
        slot_next = ring_stat.head_slot;
        status_next = ST_MISS;
        ring_ctrl.pop = fire;
        tag_ctrl.alloc = fire;
        tag_ctrl.slot = ring_stat.head_slot;
      end
    end else if (tag_stat.rel_in_use && !ring_stat.full) begin
      status_next = ST_RELEASED;
      ring_ctrl.push = fire;
      ring_ctrl.push_slot = s1_idx;
      tag_ctrl.release_en = fire;
      tag_ctrl.slot = s1_idx;
    end
  end

  bbcp_free_ring u_free_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .stat (ring_stat)
  );

  bbcp_slot_tags u_slot_tags (
    .clk        (clk),
    .rst        (rst),
    .lookup_dev (s1_dev),
    .lookup_blk (s1_blk),
    .rel_slot   (s1_idx),
    .ctrl       (tag_ctrl),
    .stat       (tag_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
    if (!in_stall) begin
      s1_mode <= mode;
      s1_dev <= device_id;
      s1_blk <= block_number;
      s1_idx <= slot_index;
    end
    if (fire) begin
      result_slot <= slot_next;
      status <= status_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/bbcp_free_ring.sv -----
// fifo ring of free slot numbers
`default_nettype none
`include "block_buffer_cache_pool_assert.svh"
module bbcp_free_ring
  import bbcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ring_ctrl_t ctrl,
  output ring_stat_t      stat
);
  logic [SLOT_W-1:0]  ring [NUM_BUFFERS];
  logic [SLOT_W-1:0]  head;
  logic [COUNT_W-1:0] count;
  logic [SLOT_W-1:0]  tail;

  assign tail = head + count[SLOT_W-1:0];
  assign stat.empty = (count == '0);
  assign stat.full = (count == COUNT_W'(NUM_BUFFERS));
  assign stat.head_slot = ring[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        ring[i] <= SLOT_W'(NUM_BUFFERS - 1 - i);
      end
      head <= '0;
      count <= COUNT_W'(NUM_BUFFERS);
    end else if (ctrl.pop) begin
      head <= head + SLOT_W'(1);
      count <= count - COUNT_W'(1);
    end else if (ctrl.push) begin
      ring[tail] <= ctrl.push_slot;
      count <= count + COUNT_W'(1);
    end
  end

  `BBCP_ASSERT(a_count_range, clk, rst, count <= COUNT_W'(NUM_BUFFERS))
  `BBCP_ASSERT(a_no_pop_empty, clk, rst, !(ctrl.pop && stat.empty))
  `BBCP_ASSERT(a_no_push_full, clk, rst, !(ctrl.push && stat.full))
  `BBCP_ASSERT_NEXT(a_pop_count, clk, rst, ctrl.pop, count == $past(count) - COUNT_W'(1))
endmodule
`default_nettype wire

// ----- rtl/core/bbcp_slot_tags.sv -----
// slot tags, in-use flags and parallel tag compare
`default_nettype none
`include "block_buffer_cache_pool_assert.svh"
module bbcp_slot_tags
  import bbcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DEV_W-1:0]  lookup_dev,
  input  wire logic [BLK_W-1:0]  lookup_blk,
  input  wire logic [SLOT_W-1:0] rel_slot,
  input  wire tag_ctrl_t         ctrl,
  output tag_stat_t              stat
);
  logic [NUM_BUFFERS-1:0] in_use;
  logic [DEV_W-1:0]       dev_tag [NUM_BUFFERS];
  logic [BLK_W-1:0]       blk_tag [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] match;

  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match[i] = in_use[i] && (dev_tag[i] == lookup_dev) && (blk_tag[i] == lookup_blk);
    end
  end

  // lowest matching slot wins
  always_comb begin
    stat.hit = |match;
    stat.hit_slot = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        stat.hit_slot = SLOT_W'(i);
      end
    end
    stat.rel_in_use = in_use[rel_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (ctrl.alloc) begin
      in_use[ctrl.slot] <= 1'b1;
    end else if (ctrl.release_en) begin
      in_use[ctrl.slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.alloc) begin
      dev_tag[ctrl.slot] <= lookup_dev;
      blk_tag[ctrl.slot] <= lookup_blk;
    end
  end

  `BBCP_ASSERT(a_alloc_free_slot, clk, rst, !(ctrl.alloc && in_use[ctrl.slot]))
  `BBCP_ASSERT(a_release_used_slot, clk, rst, !(ctrl.release_en && !in_use[ctrl.slot]))
  `BBCP_ASSERT(a_alloc_no_hit, clk, rst, !(ctrl.alloc && stat.hit))
endmodule
`default_nettype wire
